@@ rtl/core/ump_pkg.sv @@
// Package for the update manifest parser: phase codes, field codes, status codes,
// key table and character class helpers. No dependencies.
`default_nettype none
package ump_pkg;

    localparam int unsigned VersionMaxLenDef = 32;
    localparam int unsigned UrlBufferLenDef  = 256;
    localparam int unsigned DigestHexLenDef  = 64;

    localparam logic [31:0] ImageLimitRst = 32'd16777216;
    localparam logic [15:0] BodyLimitRst  = 16'd4096;

    localparam logic [3:0] PH_OPEN     = 4'd0;
    localparam logic [3:0] PH_FIRST    = 4'd1;
    localparam logic [3:0] PH_KEYSTART = 4'd2;
    localparam logic [3:0] PH_KEY      = 4'd3;
    localparam logic [3:0] PH_COLON    = 4'd4;
    localparam logic [3:0] PH_VALSTART = 4'd5;
    localparam logic [3:0] PH_STR      = 4'd6;
    localparam logic [3:0] PH_NUM      = 4'd7;
    localparam logic [3:0] PH_SKIPSTR  = 4'd8;
    localparam logic [3:0] PH_SKIPNUM  = 4'd9;
    localparam logic [3:0] PH_AFTER    = 4'd10;
    localparam logic [3:0] PH_TRAIL    = 4'd11;
    localparam logic [3:0] PH_DEAD     = 4'd12;

    localparam logic [2:0] FLD_VERSION = 3'd0;
    localparam logic [2:0] FLD_URL     = 3'd1;
    localparam logic [2:0] FLD_SHA     = 3'd2;
    localparam logic [2:0] FLD_SIZE    = 3'd3;
    localparam logic [2:0] FLD_NONE    = 3'd7;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_BIG   = 3'd2;
    localparam logic [2:0] ST_JSON  = 3'd3;
    localparam logic [2:0] ST_FIELD = 3'd4;

    localparam logic [0:0] KIND_CHAR   = 1'b0;
    localparam logic [0:0] KIND_STATUS = 1'b1;

    localparam logic [0:0] CFG_IMAGE_LIMIT = 1'b0;
    localparam logic [0:0] CFG_BODY_LIMIT  = 1'b1;

    localparam logic [16:0] CountMax = 17'h1FFFF;

    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: begin
                case (pos)
                    3'd0: c = "v"; 3'd1: c = "e"; 3'd2: c = "r"; 3'd3: c = "s";
                    3'd4: c = "i"; 3'd5: c = "o"; 3'd6: c = "n";
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0: c = "u"; 3'd1: c = "r"; 3'd2: c = "l";
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0: c = "s"; 3'd1: c = "h"; 3'd2: c = "a"; 3'd3: c = "2";
                    3'd4: c = "5"; 3'd5: c = "6";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: c = "s"; 3'd1: c = "i"; 3'd2: c = "z"; 3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [4:0] key_len(input logic [1:0] k);
        logic [4:0] n;
        case (k)
            2'd0: n = 5'd7;
            2'd1: n = 5'd3;
            2'd2: n = 5'd6;
            default: n = 5'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] scheme_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = "h"; 3'd1: c = "t"; 3'd2: c = "t"; 3'd3: c = "p";
            3'd4: c = "s"; 3'd5: c = ":"; 3'd6: c = "/";
            default: c = "/";
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/update_manifest_parser.sv @@
// Update manifest parser top level: byte-serial flat JSON checker that streams
// version, url and sha256 characters and reports a final status. Uses ump_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall): one body byte a word, with i_is_last on
//   the final word and i_empty_body for a word that carries no byte.
//   Output channel (o_valid / i_stall): a value character word (result_kind 0,
//   tagged with field_id) or, on the last input word, one status word with the
//   saturated image size.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 image_limit, index 1
//   body_limit; always ready, write only while idle.
// The result register loads directly from the accepted input word.
// Throughput: one word a cycle unless the output stalls; the parse state advances by one short
// update and a times-ten add for the size per byte.
// A stalled output holds its word; input is stalled only while the result
// register is full and the receiver stalls it.
// Reset clears the parse state and loads the limit registers with defaults.
`default_nettype none
module update_manifest_parser #(
    parameter int unsigned VERSION_MAX_LEN = ump_pkg::VersionMaxLenDef,
    parameter int unsigned URL_BUFFER_LEN  = ump_pkg::UrlBufferLenDef,
    parameter int unsigned DIGEST_HEX_LEN  = ump_pkg::DigestHexLenDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_is_last,
    input  wire logic        i_empty_body,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_result_kind,
    output logic [1:0]       o_field_id,
    output logic [7:0]       o_value_char,
    output logic [2:0]       o_status,
    output logic [31:0]      o_image_size,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam logic [8:0] VerCap = 9'(VERSION_MAX_LEN);
    localparam logic [8:0] UrlCap = 9'(URL_BUFFER_LEN - 1);
    localparam logic [8:0] ShaCap = 9'(DIGEST_HEX_LEN);

    logic [31:0] r_image_limit;
    logic [15:0] r_body_limit;

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_key_matcher, n_key_matcher;
    logic [4:0]  r_key_length, n_key_length;
    logic [2:0]  r_field, n_field;
    logic [3:0]  r_seen, n_seen;
    logic [2:0]  r_err, n_err;
    logic        r_bad, n_bad;
    logic [16:0] r_count, n_count;
    logic [8:0]  r_vlen, n_vlen;
    logic [31:0] r_size, n_size;
    logic        r_over, n_over;

    logic        r_out_valid;
    logic        r_kind;
    logic [1:0]  r_fid;
    logic [7:0]  r_char;
    logic [2:0]  r_status;
    logic [31:0] r_isize;

    logic        take;
    logic [7:0]  c;
    logic        emit_char;
    logic [2:0]  fin_status;
    logic [35:0] mul10;
    logic [35:0] acc_sum;
    logic [8:0]  cap;

    assign o_stall     = r_out_valid && i_stall;
    assign take        = i_valid && !o_stall;
    assign c           = i_data_byte;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (r_field)
            ump_pkg::FLD_VERSION: cap = VerCap;
            ump_pkg::FLD_URL:     cap = UrlCap;
            default:              cap = ShaCap;
        endcase
    end

    // Times ten as shift-add on the size accumulator.
    assign mul10   = {1'b0, r_size, 3'b000} + {3'b000, r_size, 1'b0};
    assign acc_sum = mul10 + {28'd0, c - 8'h30};

    // Next-state logic for one byte plus final status evaluation.
    always_comb begin
        logic f_fail;
        logic [2:0] f_code;
        logic do_finish;
        logic after_chk;
        logic [3:0] ph_fin;
        logic [3:0] seen_f;
        logic [2:0] err_f;
        n_phase       = r_phase;
        n_key_matcher = r_key_matcher;
        n_key_length  = r_key_length;
        n_field       = r_field;
        n_seen        = r_seen;
        n_err         = r_err;
        n_bad         = r_bad;
        n_count       = r_count;
        n_vlen        = r_vlen;
        n_size        = r_size;
        n_over        = r_over;
        emit_char     = 1'b0;
        f_fail        = 1'b0;
        f_code        = ump_pkg::ST_JSON;
        do_finish     = 1'b0;
        after_chk     = 1'b0;
        fin_status    = ump_pkg::ST_OK;
        ph_fin        = r_phase;
        seen_f        = r_seen;
        err_f         = r_err;

        if (!i_empty_body) begin
            if (r_count != ump_pkg::CountMax) n_count = r_count + 17'd1;
            case (r_phase)
                ump_pkg::PH_OPEN: begin
                    if (c == "{") n_phase = ump_pkg::PH_FIRST;
                    else if (!ump_pkg::is_ws(c)) f_fail = 1'b1;
                end
                ump_pkg::PH_FIRST, ump_pkg::PH_KEYSTART: begin
                    if (ump_pkg::is_ws(c)) begin
                    end else if (c == "}" && r_phase == ump_pkg::PH_FIRST) begin
                        n_phase = ump_pkg::PH_TRAIL;
                    end else if (c == 8'h22) begin
                        n_phase       = ump_pkg::PH_KEY;
                        n_key_matcher = 4'hF;
                        n_key_length  = 5'd0;
                    end else begin
                        f_fail = 1'b1;
                    end
                end
                ump_pkg::PH_KEY: begin
                    if (c == 8'h22) begin
                        n_field = ump_pkg::FLD_NONE;
                        for (int k = 0; k < 4; k++) begin
                            if (r_key_matcher[k] && r_key_length == ump_pkg::key_len(2'(k)))
                                n_field = 3'(k);
                        end
                        n_phase = ump_pkg::PH_COLON;
                    end else if (c == 8'h5C || c < 8'h20) begin
                        f_fail = 1'b1;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            if (r_key_length >= ump_pkg::key_len(2'(k)) ||
                                ump_pkg::key_char(2'(k), r_key_length[2:0]) != c)
                                n_key_matcher[k] = 1'b0;
                        end
                        if (r_key_length < 5'd31) n_key_length = r_key_length + 5'd1;
                    end
                end
                ump_pkg::PH_COLON: begin
                    if (c == ":") n_phase = ump_pkg::PH_VALSTART;
                    else if (!ump_pkg::is_ws(c)) f_fail = 1'b1;
                end
                ump_pkg::PH_VALSTART: begin
                    if (ump_pkg::is_ws(c)) begin
                    end else if (r_field == ump_pkg::FLD_SIZE) begin
                        if (ump_pkg::is_digit(c)) begin
                            n_phase = ump_pkg::PH_NUM;
                            n_size  = {24'd0, c - 8'h30};
                        end else begin
                            f_fail = 1'b1;
                        end
                    end else if (r_field <= ump_pkg::FLD_SHA) begin
                        if (c == 8'h22) begin
                            n_phase = ump_pkg::PH_STR;
                            n_vlen  = 9'd0;
                            n_over  = 1'b0;
                        end else begin
                            f_fail = 1'b1;
                        end
                    end else if (c == 8'h22) begin
                        n_phase = ump_pkg::PH_SKIPSTR;
                    end else if (ump_pkg::is_digit(c)) begin
                        n_phase = ump_pkg::PH_SKIPNUM;
                    end else begin
                        f_fail = 1'b1;
                    end
                end
                ump_pkg::PH_STR: begin
                    if (c == 8'h22) begin
                        if (r_field == ump_pkg::FLD_VERSION && r_vlen == 9'd0) n_bad = 1'b1;
                        if (r_field == ump_pkg::FLD_URL && r_vlen < 9'd9) n_bad = 1'b1;
                        if (r_field == ump_pkg::FLD_SHA && r_vlen != ShaCap) n_bad = 1'b1;
                        do_finish = 1'b1;
                    end else if (c == 8'h5C || c < 8'h20) begin
                        f_fail = 1'b1;
                    end else if (r_vlen >= cap) begin
                        n_over = 1'b1;
                    end else begin
                        if (r_field == ump_pkg::FLD_VERSION) begin
                            if (!((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                                  ump_pkg::is_digit(c) || c == "." || c == "-" || c == "_"))
                                n_bad = 1'b1;
                        end else if (r_field == ump_pkg::FLD_URL) begin
                            if (r_vlen < 9'd8 && c != ump_pkg::scheme_char(r_vlen[2:0]))
                                n_bad = 1'b1;
                        end else begin
                            if (!(ump_pkg::is_digit(c) || (c >= "a" && c <= "f")))
                                n_bad = 1'b1;
                        end
                        n_vlen    = r_vlen + 9'd1;
                        emit_char = 1'b1;
                    end
                end
                ump_pkg::PH_NUM: begin
                    if (ump_pkg::is_digit(c)) begin
                        if (acc_sum[35:32] != 4'd0) begin
                            n_size = 32'hFFFF_FFFF;
                            f_code = ump_pkg::ST_FIELD;
                            f_fail = 1'b1;
                        end else begin
                            n_size = acc_sum[31:0];
                        end
                    end else begin
                        do_finish = 1'b1;
                        after_chk = 1'b1;
                    end
                end
                ump_pkg::PH_SKIPSTR: begin
                    if (c == 8'h22) n_phase = ump_pkg::PH_AFTER;
                    else if (c == 8'h5C || c < 8'h20) f_fail = 1'b1;
                end
                ump_pkg::PH_SKIPNUM: begin
                    if (!ump_pkg::is_digit(c)) begin
                        n_phase   = ump_pkg::PH_AFTER;
                        after_chk = 1'b1;
                    end
                end
                ump_pkg::PH_AFTER: after_chk = 1'b1;
                ump_pkg::PH_TRAIL: begin
                    if (!ump_pkg::is_ws(c)) f_fail = 1'b1;
                end
                default: begin
                end
            endcase

            // Close a value: check buffer overflow and duplicates.
            if (do_finish) begin
                n_phase = ump_pkg::PH_AFTER;
                if (r_field <= ump_pkg::FLD_SIZE) begin
                    if (n_over || r_seen[r_field[1:0]]) begin
                        f_fail = 1'b1;
                        f_code = ump_pkg::ST_FIELD;
                        after_chk = 1'b0;
                    end else begin
                        n_seen[r_field[1:0]] = 1'b1;
                    end
                end
            end
            if (after_chk && !f_fail) begin
                if (ump_pkg::is_ws(c)) begin
                end else if (c == ",") n_phase = ump_pkg::PH_KEYSTART;
                else if (c == "}") n_phase = ump_pkg::PH_TRAIL;
                else f_fail = 1'b1;
            end
            if (f_fail) begin
                if (r_err == ump_pkg::ST_OK) n_err = f_code;
                n_phase = ump_pkg::PH_DEAD;
            end
        end

        // Final status from the post-byte state; a trailing number completes here.
        seen_f = n_seen;
        err_f  = n_err;
        ph_fin = n_phase;
        if (n_err == ump_pkg::ST_OK && n_phase == ump_pkg::PH_NUM) begin
            ph_fin = ump_pkg::PH_AFTER;
            if (n_seen[3]) err_f = ump_pkg::ST_FIELD;
            else seen_f[3] = 1'b1;
        end
        if (n_count == 17'd0) fin_status = ump_pkg::ST_EMPTY;
        else if (n_count > {1'b0, r_body_limit}) fin_status = ump_pkg::ST_BIG;
        else if (err_f != ump_pkg::ST_OK) fin_status = err_f;
        else if (ph_fin != ump_pkg::PH_TRAIL) fin_status = ump_pkg::ST_JSON;
        else if (seen_f != 4'hF) fin_status = ump_pkg::ST_FIELD;
        else if (n_bad || n_size == 32'd0 || n_size > r_image_limit)
            fin_status = ump_pkg::ST_FIELD;
        else fin_status = ump_pkg::ST_OK;
    end

    // Hold limits; update on config writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_limit <= ump_pkg::ImageLimitRst;
            r_body_limit  <= ump_pkg::BodyLimitRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ump_pkg::CFG_IMAGE_LIMIT: r_image_limit <= i_cfg_data;
                ump_pkg::CFG_BODY_LIMIT:  r_body_limit  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Advance parse state; return to reset after the last word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_is_last)) begin
            r_phase       <= ump_pkg::PH_OPEN;
            r_key_matcher <= 4'd0;
            r_key_length  <= 5'd0;
            r_field       <= ump_pkg::FLD_NONE;
            r_seen        <= 4'd0;
            r_err         <= ump_pkg::ST_OK;
            r_bad         <= 1'b0;
            r_count       <= 17'd0;
            r_vlen        <= 9'd0;
            r_size        <= 32'd0;
            r_over        <= 1'b0;
        end else if (take) begin
            r_phase       <= n_phase;
            r_key_matcher <= n_key_matcher;
            r_key_length  <= n_key_length;
            r_field       <= n_field;
            r_seen        <= n_seen;
            r_err         <= n_err;
            r_bad         <= n_bad;
            r_count       <= n_count;
            r_vlen        <= n_vlen;
            r_size        <= n_size;
            r_over        <= n_over;
        end
    end

    // Result register: load a character or status word, drop it when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && (i_is_last || (emit_char && n_err == ump_pkg::ST_OK &&
                                            n_count <= {1'b0, r_body_limit}))) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (i_is_last) begin
                r_kind   <= ump_pkg::KIND_STATUS;
                r_fid    <= 2'd0;
                r_char   <= 8'd0;
                r_status <= fin_status;
                r_isize  <= (fin_status == ump_pkg::ST_EMPTY ||
                             fin_status == ump_pkg::ST_BIG) ? 32'd0 : n_size;
            end else begin
                r_kind   <= ump_pkg::KIND_CHAR;
                r_fid    <= r_field[1:0];
                r_char   <= c;
                r_status <= ump_pkg::ST_OK;
                r_isize  <= 32'd0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_field_id    = r_fid;
    assign o_value_char  = r_char;
    assign o_status      = r_status;
    assign o_image_size  = r_isize;

    a_status_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_is_last) |=> (r_phase == ump_pkg::PH_OPEN && r_count == 17'd0))
        else $error("parse state not cleared after status");
    a_dead_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ump_pkg::PH_DEAD) |-> (r_err != ump_pkg::ST_OK))
        else $error("dead phase without error code");
    a_char_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == ump_pkg::KIND_CHAR) |-> (o_field_id != 2'd3))
        else $error("character word with size field tag");

endmodule
`default_nettype wire
